// ----- design/mlta_pkg.sv -----
// mlta_pkg: shared types and constants for the mac learning table with aging
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package mlta_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int PORT_COUNT    = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int MAC_W         = 48;
	localparam int PORT_W        = 4;
	localparam int AGE_W         = 6;
	localparam int REMOVED_W     = 9;

	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(30);

	// command codes
	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// request word
	typedef struct packed {
		cmd_t              command;
		logic [MAC_W-1:0]  mac_address;
		logic [PORT_W-1:0] port_number;
	} in_word_t;

	// result word
	typedef struct packed {
		logic                 hit;
		logic [PORT_W-1:0]    found_port;
		logic                 insert_dropped;
		logic [REMOVED_W-1:0] removed_count;
	} out_word_t;

	// one table row as held in the memory
	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [AGE_W-1:0]  age;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} sts_t;

endpackage

// ----- design/mlta_ctrl.sv -----
// mlta_ctrl: sequencer that walks the table once per command
// depends on mlta_pkg
`timescale 1ns / 1ps

module mlta_ctrl
	import mlta_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (sts.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// commands to the datapath
	always_comb begin
		ctl.load   = (state_q == ST_IDLE) && start;
		ctl.scan   = (state_q == ST_SCAN);
		ctl.finish = (state_q == ST_FINISH);
	end

	assign busy = busy_q;

	// busy follows the state
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy flag out of step with state");

	// a scan always ends by draining then finishing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_FINISH))
		else $error("drain not followed by finish");

	// a new word starts a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == ST_SCAN))
		else $error("accepted word did not start a scan");

endmodule

// ----- design/mlta_dpath.sv -----
// mlta_dpath: table memory, valid bits, scan counter and result registers
// depends on mlta_pkg
`timescale 1ns / 1ps

module mlta_dpath
	import mlta_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  in_word_t         request,
	input  logic [AGE_W-1:0] age_limit,
	output sts_t             sts,
	output logic             done,
	output out_word_t        result
);

	// table storage
	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// captured request
	cmd_t              cmd_q;
	logic [MAC_W-1:0]  mac_q;
	logic [PORT_W-1:0] port_q;

	// scan counter and read stage
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_s1;
	logic             vld_s1;
	logic             act_s1;

	// scan findings
	logic                 match_found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [PORT_W-1:0]    match_port_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [REMOVED_W-1:0] removed_q;

	// result
	logic      done_q;
	out_word_t result_q;

	logic             port_ok;
	logic [AGE_W:0]   next_age;
	logic             expire;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	assign port_ok  = (32'(port_q) < PORT_COUNT);
	assign next_age = {1'b0, rd_s1.age} + (AGE_W+1)'(1);
	assign expire   = next_age > {1'b0, age_limit};
	assign sts.last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));

	// memory write select: aging during the scan, learn or refresh at finish
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_s1;
		if (act_s1 && (cmd_q == CMD_TICK) && vld_s1 && !expire) begin
			wr_en       = 1'b1;
			wr_data.age = next_age[AGE_W-1:0];
		end else if (ctl.finish && (cmd_q == CMD_LOOKUP) && match_found_q) begin
			wr_en   = 1'b1;
			wr_addr = match_idx_q;
			wr_data = '{mac: mac_q, port: match_port_q, age: '0};
		end else if (ctl.finish && (cmd_q == CMD_INSERT) && port_ok &&
				(match_found_q || free_found_q)) begin
			wr_en   = 1'b1;
			wr_addr = match_found_q ? match_idx_q : free_idx_q;
			wr_data = '{mac: mac_q, port: port_q, age: '0};
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.scan) begin
			rd_s1 <= mem[idx_q];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (act_s1 && (cmd_q == CMD_TICK) && vld_s1 && expire) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (ctl.finish && (cmd_q == CMD_INSERT) && port_ok &&
					!match_found_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// request capture and read stage payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= request.command;
			mac_q  <= request.mac_address;
			port_q <= request.port_number;
		end
		if (ctl.scan) begin
			idx_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q];
		end
	end

	// scan counter, findings and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			act_s1        <= 1'b0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_port_q  <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			removed_q     <= '0;
			done_q        <= 1'b0;
			result_q      <= '0;
		end else begin
			act_s1 <= ctl.scan;
			done_q <= ctl.finish;
			if (ctl.load) begin
				idx_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				removed_q     <= '0;
			end else if (ctl.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// lowest matching valid entry
			if (act_s1 && (cmd_q == CMD_LOOKUP || cmd_q == CMD_INSERT) &&
					vld_s1 && (rd_s1.mac == mac_q) && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_port_q  <= rd_s1.port;
			end
			// lowest free slot
			if (act_s1 && !vld_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			// aged out count
			if (act_s1 && (cmd_q == CMD_TICK) && vld_s1 && expire) begin
				removed_q <= removed_q + REMOVED_W'(1);
			end
			// result word
			if (ctl.finish) begin
				result_q.hit            <= (cmd_q == CMD_LOOKUP) && match_found_q;
				result_q.found_port     <= ((cmd_q == CMD_LOOKUP) && match_found_q) ?
					match_port_q : '0;
				result_q.insert_dropped <= (cmd_q == CMD_INSERT) && port_ok &&
					!match_found_q && !free_found_q;
				result_q.removed_count  <= (cmd_q == CMD_TICK) ? removed_q : '0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// the read stage is only busy in the cycle after a scan cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		act_s1 |-> $past(ctl.scan))
		else $error("read stage active without a scan");

	// a hit only comes from a lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.hit) |-> (cmd_q == CMD_LOOKUP))
		else $error("hit reported outside a lookup");

	// the finish write never collides with an aging write
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !act_s1)
		else $error("finish overlaps the read stage");

endmodule

// ----- design/mac_learning_table_aging.sv -----
// mac_learning_table_aging: each command walks the table one entry per cycle,
// scanning in ST_SCAN, then passing ST_DRAIN and ST_FINISH before the done strobe
// a new command is taken only once the last is done, set by the single read port scan
// result held from the done strobe until the next finish, the receiver cannot stall
// reset clears the valid bits at once (table empty) and sets age_limit to 30
`timescale 1ns / 1ps

module mac_learning_table_aging
	import mlta_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_word_t         request,
	output logic             done,
	output out_word_t        result,
	input  logic             cfg_we,
	input  logic [AGE_W-1:0] cfg_wdata
);

	ctl_t             ctl;
	sts_t             sts;
	logic [AGE_W-1:0] age_limit_q;

	// age limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (cfg_we) begin
			age_limit_q <= cfg_wdata;
		end
	end

	mlta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	mlta_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.request   (request),
		.age_limit (age_limit_q),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

	// done is a single cycle strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// an accepted word raises busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepting a word");

	// the result word appears as the block goes idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $fell(busy)))
		else $error("done outside the end of a command");

endmodule
